@@ sv/mtfe_pkg.sv @@
// Shared types and constants for the move-to-front encoder.
// Holds the command codes, result kinds and the controller/datapath buses.
// No dependencies.
package mtfe_pkg;

  // Fixed field widths
  localparam int SYM_W  = 8;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 9;
  localparam int CMD_W  = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Input item kinds, carried on the slave tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_ENCODE = 2'd3
  } cmd_e;

  // Kind of result word to load into the output register
  typedef enum logic [1:0] {
    RES_BUILD = 2'd0,
    RES_HIT   = 2'd1,
    RES_MISS  = 2'd2
  } res_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      clr_map;    // empty the alphabet and the list
    logic      set_map;    // mark the incoming symbol
    logic      latch_sym;  // capture the incoming symbol
    logic      ptr_clr;    // rewind the walk pointer and the fill count
    logic      ptr_inc;
    logic      ptr_dec;
    logic      bld_step;   // examine one alphabet entry, append if present
    logic      rd_shift;   // read address is pointer minus one
    logic      found;      // capture the match position
    logic      wr_shift;   // move the word read back by one slot
    logic      wr_front;   // write the symbol to the head
    logic      out_load;
    res_kind_e kind;
  } mtfe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sym_ok;     // incoming symbol lies inside the alphabet
    logic len_zero;
    logic bld_last;   // walk pointer at the last alphabet entry
    logic match;      // word read equals the held symbol
    logic srch_last;  // walk pointer at the last list entry
    logic ptr_zero;
    logic ptr_one;
    logic out_busy;   // result register full and not taken this cycle
  } mtfe_sts_t;

endpackage

@@ sv/mtfe_dpath.sv @@
// Datapath of the move-to-front encoder: alphabet map, list memory,
// walk pointer and result register. Depends on mtfe_pkg.
module mtfe_dpath #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mtfe_pkg::mtfe_cmd_t                 cmd_i,
  output mtfe_pkg::mtfe_sts_t                 sts_o,
  input  logic [mtfe_pkg::IN_TDATA_W-1:0]     sym_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mtfe_pkg::POS_W-1:0]          out_pos_o,
  output logic [mtfe_pkg::CNT_W-1:0]          out_cnt_o,
  output logic                                out_nf_o
);
  import mtfe_pkg::*;

  localparam int AW = $clog2(ALPHABET_SIZE);

  logic [ALPHABET_SIZE-1:0] map_q;
  logic [SYM_W-1:0]         mem [ALPHABET_SIZE];
  logic [SYM_W-1:0]         rdata_q;
  logic [SYM_W-1:0]         sym_q;
  logic [AW-1:0]            ptr_q;
  logic [AW-1:0]            pos_q;
  logic [CNT_W-1:0]         n_q;
  logic [CNT_W-1:0]         len_q;
  logic                     out_valid_q;
  logic [POS_W-1:0]         out_pos_q;
  logic [CNT_W-1:0]         out_cnt_q;
  logic                     out_nf_q;

  logic                     sym_ok;
  logic                     map_bit;
  logic [CNT_W-1:0]         n_next;
  logic [AW-1:0]            raddr;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [SYM_W-1:0]         wdata;

  assign sym_ok  = {1'b0, sym_data_i} < CNT_W'(ALPHABET_SIZE);
  assign map_bit = map_q[ptr_q];
  assign n_next  = n_q + CNT_W'(map_bit);
  assign raddr   = cmd_i.rd_shift ? AW'(ptr_q - AW'(1)) : ptr_q;

  // Pick the single write of this cycle
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = rdata_q;
    if (cmd_i.bld_step) begin
      we    = map_bit;
      waddr = n_q[AW-1:0];
      wdata = SYM_W'(ptr_q);
    end else if (cmd_i.wr_shift) begin
      we    = 1'b1;
      waddr = ptr_q;
      wdata = rdata_q;
    end else if (cmd_i.wr_front) begin
      we    = 1'b1;
      waddr = '0;
      wdata = sym_q;
    end
  end

  // List memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Alphabet map and list length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
      len_q <= '0;
    end else if (cmd_i.clr_map) begin
      map_q <= '0;
      len_q <= '0;
    end else begin
      if (cmd_i.set_map && sym_ok) begin
        map_q[sym_data_i[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.bld_step && (ptr_q == AW'(ALPHABET_SIZE - 1))) begin
        len_q <= n_next;
      end
    end
  end

  // Walk pointer, fill count, held symbol and match position
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_sym) begin
      sym_q <= sym_data_i;
    end
    if (cmd_i.found) begin
      pos_q <= ptr_q;
    end
    if (cmd_i.ptr_clr) begin
      ptr_q <= '0;
      n_q   <= '0;
    end else if (cmd_i.bld_step) begin
      ptr_q <= AW'(ptr_q + AW'(1));
      n_q   <= n_next;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= AW'(ptr_q + AW'(1));
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= AW'(ptr_q - AW'(1));
    end
  end

  // Result register: hold the word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cnt_q <= len_q;
      case (cmd_i.kind)
        RES_HIT: begin
          out_pos_q <= POS_W'(pos_q);
          out_nf_q  <= 1'b0;
        end
        RES_MISS: begin
          out_pos_q <= '0;
          out_nf_q  <= 1'b1;
        end
        default: begin
          out_pos_q <= '0;
          out_nf_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pos_o   = out_pos_q;
  assign out_cnt_o   = out_cnt_q;
  assign out_nf_o    = out_nf_q;

  // Status back to the controller
  always_comb begin
    sts_o.sym_ok    = sym_ok;
    sts_o.len_zero  = (len_q == '0);
    sts_o.bld_last  = (ptr_q == AW'(ALPHABET_SIZE - 1));
    sts_o.match     = (rdata_q == sym_q);
    sts_o.srch_last = ((CNT_W'(ptr_q) + CNT_W'(1)) == len_q);
    sts_o.ptr_zero  = (ptr_q == '0);
    sts_o.ptr_one   = (ptr_q == AW'(1));
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(ALPHABET_SIZE))
    else $error("list length exceeds alphabet size");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_nf_q |-> out_pos_q == '0)
    else $error("miss result carries a nonzero position");
`endif

endmodule

@@ sv/mtfe_ctrl.sv @@
// Controller of the move-to-front encoder: sequences build, search and
// shift steps over the datapath. Depends on mtfe_pkg.
module mtfe_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [mtfe_pkg::CMD_W-1:0]      in_cmd_i,
  output logic                            in_ready_o,
  input  mtfe_pkg::mtfe_sts_t             sts_i,
  output mtfe_pkg::mtfe_cmd_t             cmd_o
);
  import mtfe_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_BUILD    = 8'b0000_0010,
    ST_SRCH_RD  = 8'b0000_0100,
    ST_SRCH_CMP = 8'b0000_1000,
    ST_SH_RD    = 8'b0001_0000,
    ST_SH_WR    = 8'b0010_0000,
    ST_FRONT    = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_e;

  state_e    state_q, state_d;
  res_kind_e kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= RES_BUILD;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (cmd_e'(in_cmd_i))
            CMD_CLEAR: cmd_o.clr_map = 1'b1;
            CMD_MARK:  cmd_o.set_map = 1'b1;
            CMD_BUILD: begin
              cmd_o.ptr_clr = 1'b1;
              state_d       = ST_BUILD;
            end
            CMD_ENCODE: begin
              cmd_o.latch_sym = 1'b1;
              cmd_o.ptr_clr   = 1'b1;
              if (!sts_i.sym_ok || sts_i.len_zero) begin
                kind_d  = RES_MISS;
                state_d = ST_FINISH;
              end else begin
                state_d = ST_SRCH_RD;
              end
            end
            default: ;
          endcase
        end
      end
      // Walk the whole alphabet, appending present bytes
      ST_BUILD: begin
        cmd_o.bld_step = 1'b1;
        if (sts_i.bld_last) begin
          kind_d  = RES_BUILD;
          state_d = ST_FINISH;
        end
      end
      ST_SRCH_RD: begin
        state_d = ST_SRCH_CMP;
      end
      // Compare one list entry against the symbol
      ST_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.found = 1'b1;
          kind_d      = RES_HIT;
          state_d     = sts_i.ptr_zero ? ST_FINISH : ST_SH_RD;
        end else if (sts_i.srch_last) begin
          kind_d  = RES_MISS;
          state_d = ST_FINISH;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = ST_SRCH_RD;
        end
      end
      ST_SH_RD: begin
        cmd_o.rd_shift = 1'b1;
        state_d        = ST_SH_WR;
      end
      // Move the entry ahead back one slot
      ST_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_dec  = 1'b1;
        state_d        = sts_i.ptr_one ? ST_FRONT : ST_SH_RD;
      end
      ST_FRONT: begin
        cmd_o.wr_front = 1'b1;
        state_d        = ST_FINISH;
      end
      // Hand the result over once the output register is free
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_shift_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_shift |-> !sts_i.ptr_zero)
    else $error("shift write at the list head");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("result loaded over an untaken word");

  a_front_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FRONT |=> state_q == ST_FINISH && kind_q == RES_HIT)
    else $error("head write not followed by a hit result");
`endif

endmodule

@@ sv/move_to_front_encoder_core.sv @@
// Byte move-to-front encoder, top level.
// Channels: slave stream takes one command word per handshake; tuser holds
//   the command (clear, mark, build, encode) and tdata the symbol byte.
//   Master stream returns one result word for each build and encode;
//   clear and mark return nothing.
// Use: clear, mark every byte of the alphabet, build, then encode bytes.
// Steps per item:
//   clear, mark: done in the idle state as the word is taken.
//   build: one alphabet entry examined per cycle, present bytes appended.
//   encode: list entries read and compared in turn; after a hit past the
//   head the entries ahead move back one slot each and the symbol goes to
//   the head. An out-of-alphabet symbol or an empty list misses unsearched.
//   Search and shift share the list memory's single read and write port.
// One item is in work at a time; a result waits in the output register
// while the next item is accepted, and a finishing item holds until that
// register is taken, so a stalled receiver only delays build and encode.
// Reset empties the alphabet and sets the list length to zero; the list
// memory needs no clearing because only entries written by a build are read.
module move_to_front_encoder_core #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] position, [16:8] unique_count, [23:17] zero
  output logic        m_axis_tuser    // [0] not_found
);
  import mtfe_pkg::*;

  mtfe_cmd_t        cmd;
  mtfe_sts_t        sts;
  logic [POS_W-1:0] out_pos;
  logic [CNT_W-1:0] out_cnt;

  mtfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtfe_dpath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sym_data_i  (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_pos_o   (out_pos),
    .out_cnt_o   (out_cnt),
    .out_nf_o    (m_axis_tuser)
  );

  // Pack the result word
  assign m_axis_tdata = {(OUT_TDATA_W - POS_W - CNT_W)'(0), out_cnt, out_pos};

endmodule

@@ bench/mtfe_checker.sv @@
// Checker for the move-to-front encoder: watches both stream channels,
// predicts each result word and compares it with the one returned.
// Depends on mtfe_pkg for the command codes.
`timescale 1ns / 1ps

module mtfe_checker #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] position, [16:8] unique_count, [23:17] zero
  input  logic        m_axis_tuser,   // [0] not_found
  output int          fail_count,
  output int          pending,
  output int          build_seen,
  output int          hit_seen,
  output int          miss_seen
);
  import mtfe_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] unique_count;
    logic             not_found;
  } mtf_result_t;

  // Shadow copy of the alphabet, the list and its length
  logic [255:0]     alphabet_map;
  logic [SYM_W-1:0] mtf_list [256];
  int               list_len;
  mtf_result_t      result_q [$];

  // Apply one command word to the shadow state, queue its result if any
  task automatic predict_word(cmd_e op, logic [SYM_W-1:0] sym);
    mtf_result_t r;
    int          n;
    int          hit_at;
    r      = '0;
    n      = 0;
    hit_at = -1;
    case (op)
      CMD_CLEAR: begin
        alphabet_map = '0;
        list_len     = 0;
      end
      CMD_MARK: begin
        if (int'(sym) < ALPHABET_SIZE) alphabet_map[sym] = 1'b1;
      end
      CMD_BUILD: begin
        // list every present byte in ascending order
        for (int i = 0; i < ALPHABET_SIZE && i < 256; i++) begin
          if (alphabet_map[i]) begin
            mtf_list[n] = 8'(i);
            n++;
          end
        end
        list_len       = n;
        r.unique_count = 9'(n);
        build_seen++;
        result_q.push_back(r);
      end
      default: begin
        // search, then move the hit to the head
        if (int'(sym) < ALPHABET_SIZE) begin
          for (int i = 0; i < list_len; i++) begin
            if (mtf_list[i] == sym) begin
              hit_at = i;
              break;
            end
          end
        end
        if (hit_at >= 0) begin
          for (int i = hit_at; i > 0; i--) mtf_list[i] = mtf_list[i-1];
          mtf_list[0] = sym;
          r.position  = 8'(hit_at);
          hit_seen++;
        end else begin
          r.not_found = 1'b1;
          miss_seen++;
        end
        r.unique_count = 9'(list_len);
        result_q.push_back(r);
      end
    endcase
  endtask

  // Predict on accepted command words, compare on accepted result words
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    mtf_result_t want;
    logic        bad;
    if (!rst_ni) begin
      alphabet_map = '0;
      list_len     = 0;
      result_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(cmd_e'(s_axis_tuser), s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          bad  = 1'b0;
          if (m_axis_tdata[7:0] !== want.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, m_axis_tdata[7:0]);
            bad = 1'b1;
          end
          if (m_axis_tdata[16:8] !== want.unique_count) begin
            $display("%0t: unique_count mismatch, expected %0d, got %0d",
                     $time, want.unique_count, m_axis_tdata[16:8]);
            bad = 1'b1;
          end
          if (m_axis_tuser !== want.not_found) begin
            $display("%0t: not_found mismatch, expected %b, got %b",
                     $time, want.not_found, m_axis_tuser);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
    end
    pending = result_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the move-to-front encoder bench: clock, reset, command stimulus,
// random stalls on both channels and the verdict.
// Depends on mtfe_pkg, move_to_front_encoder_core and mtfe_checker.
`timescale 1ns / 1ps

module tb_top;
  import mtfe_pkg::*;

  localparam int ALPHA          = 256;
  localparam int ITEM_TARGET    = 1850;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 1100;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count;
  int pending;
  int build_seen;
  int hit_seen;
  int miss_seen;
  int words_sent;
  int quiet_cycles;
  int sessions;
  bit src_idle_en;
  bit snk_idle_en;

  // bytes marked since the last clear, used to pick encode symbols
  logic [7:0] marked_q [$];

  move_to_front_encoder_core #(
    .ALPHABET_SIZE(ALPHA)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  mtfe_checker #(
    .ALPHABET_SIZE(ALPHA)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .build_seen   (build_seen),
    .hit_seen     (hit_seen),
    .miss_seen    (miss_seen)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Present one command word, with an optional idle burst ahead of it
  task automatic send_word(cmd_e op, logic [7:0] sym);
    if (src_idle_en && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= sym;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // One alphabet: optional clear, marks, build, then mostly encodes
  task automatic run_session(int size, bit do_clear);
    logic [7:0] sym;
    logic [7:0] last_sym;
    int         offset;
    int         n_enc;
    int         pick;
    last_sym = 8'($urandom);
    if (do_clear) begin
      send_word(CMD_CLEAR, 8'($urandom));
      marked_q.delete();
      // list is empty now, so this encode must miss
      if ($urandom_range(0, 7) == 0) send_word(CMD_ENCODE, 8'($urandom));
    end
    if (size >= 256) begin
      offset = $urandom_range(0, 255);
      for (int i = 0; i < 256; i++) begin
        sym = 8'(i + offset);
        send_word(CMD_MARK, sym);
        marked_q.push_back(sym);
      end
    end else begin
      repeat (size) begin
        // now and then repeat an earlier mark
        if (marked_q.size() > 0 && $urandom_range(0, 4) == 0)
          sym = marked_q[$urandom_range(0, marked_q.size() - 1)];
        else
          sym = 8'($urandom);
        send_word(CMD_MARK, sym);
        marked_q.push_back(sym);
      end
    end
    send_word(CMD_BUILD, 8'($urandom));
    n_enc = (size >= 256) ? 24 : $urandom_range(4, 40);
    repeat (n_enc) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_word(CMD_ENCODE, last_sym);
      end else if (pick < 80 && marked_q.size() > 0) begin
        last_sym = marked_q[$urandom_range(0, marked_q.size() - 1)];
        send_word(CMD_ENCODE, last_sym);
      end else if (pick < 88) begin
        send_word(CMD_ENCODE, 8'($urandom));
      end else if (pick < 93) begin
        // mark after build: map changes, list does not until rebuilt
        sym = 8'($urandom);
        send_word(CMD_MARK, sym);
        marked_q.push_back(sym);
      end else if (pick < 97) begin
        send_word(CMD_BUILD, 8'($urandom));
      end else begin
        send_word(CMD_CLEAR, 8'($urandom));
        marked_q.delete();
      end
    end
  endtask

  // Result side: ready with random stall bursts
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (snk_idle_en && $urandom_range(0, 11) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Command stimulus and verdict
  initial begin
    int size;
    int pick;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= CMD_CLEAR;
    s_axis_tdata  <= 8'h00;
    src_idle_en   = 1'b1;
    snk_idle_en   = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // encode before any build: list is empty
    send_word(CMD_ENCODE, 8'h00);
    send_word(CMD_ENCODE, 8'hFF);
    // build from an empty alphabet
    send_word(CMD_BUILD, 8'h00);
    // small alphabet with byte 255 and a repeated mark
    send_word(CMD_MARK, 8'hFF);
    send_word(CMD_MARK, 8'h00);
    send_word(CMD_MARK, 8'h00);
    send_word(CMD_MARK, 8'hAA);
    send_word(CMD_MARK, 8'h55);
    send_word(CMD_BUILD, 8'hFF);
    send_word(CMD_ENCODE, 8'hFF);
    send_word(CMD_ENCODE, 8'hFF);
    send_word(CMD_ENCODE, 8'h00);
    send_word(CMD_ENCODE, 8'h7F);
    // marked after build: still absent from the list
    send_word(CMD_MARK, 8'h7F);
    send_word(CMD_ENCODE, 8'h7F);
    // rebuild drops the reordering
    send_word(CMD_BUILD, 8'h00);
    send_word(CMD_ENCODE, 8'hFF);
    send_word(CMD_ENCODE, 8'h7F);
    // clear empties the list too
    send_word(CMD_CLEAR, 8'hFF);
    send_word(CMD_ENCODE, 8'h00);
    send_word(CMD_BUILD, 8'hAA);

    // random alphabets, mostly small, two full ones
    while (words_sent < ITEM_TARGET) begin
      sessions++;
      if (words_sent > ITEM_TARGET * 85 / 100) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end else begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (sessions == 1 || sessions == 25) size = 256;
      else if (pick < 6) size = 0;
      else size = $urandom_range(1, 24);
      run_session(size, (sessions == 1) || ($urandom_range(0, 7) != 0));
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d command words in %0d alphabets; results checked: %0d builds, %0d hits, %0d misses",
             words_sent, sessions, build_seen, hit_seen, miss_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
